// ===== src/scanline_polygon_span_fill_unit_defines.svh =====
// Assertion helpers shared by the span fill unit
`ifndef SCANLINE_POLYGON_SPAN_FILL_UNIT_DEFINES_SVH
`define SCANLINE_POLYGON_SPAN_FILL_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SPF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/spf_pkg.sv =====
package spf_pkg;

    localparam int MAX_VERTICES  = 128;
    localparam int MAX_CROSSINGS = 16;
    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 160;
    localparam int MAX_RESULTS   = 8;

    localparam int COORD_W  = 16;
    localparam int ROW_W    = 11;
    localparam int COL_W    = 10;
    localparam int COLOR_W  = 16;
    localparam int VADDR_W  = $clog2(MAX_VERTICES);
    localparam int VCNT_W   = $clog2(MAX_VERTICES + 1);
    localparam int XIDX_W   = $clog2(MAX_CROSSINGS);
    localparam int XCNT_W   = $clog2(MAX_CROSSINGS + 1);
    localparam int RES_W    = $clog2(MAX_RESULTS + 1);
    localparam int DIV_STEPS = 16;
    localparam int DIVC_W   = $clog2(DIV_STEPS);

    localparam int SDATA_W  = 32;
    localparam int MDATA_W  = 48;
    localparam int PADDR_W  = 3;

    localparam logic CMD_VERTEX = 1'b0;
    localparam logic CMD_ROW    = 1'b1;

    localparam logic REG_FILL_COLOR = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NONE,
        ST_INIT,
        ST_FETCH,
        ST_LOAD,
        ST_TEST,
        ST_MUL,
        ST_DIV,
        ST_STORE,
        ST_NEXT,
        ST_SORT,
        ST_PAIR,
        ST_FINISH
    } spf_state_t;

    typedef struct packed {
        logic vtx_load;
        logic row_init;
        logic load;
        logic test;
        logic mul;
        logic div_step;
        logic store;
        logic next;
        logic sort_step;
        logic pair_step;
        logic emit_final;
        logic emit_none;
    } spf_cmd_t;

    typedef struct packed {
        logic nothing_left;
        logic first;
        logic last_edge;
        logic hit;
        logic div_done;
        logic sort_done;
        logic pair_more;
        logic span_ok;
        logic pend_valid;
        logic out_free;
    } spf_stat_t;

endpackage

// ===== src/spf_ctrl.sv =====
`include "scanline_polygon_span_fill_unit_defines.svh"

module spf_ctrl
    import spf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_axis_tvalid,
    input  logic      s_axis_tuser,
    output logic      s_axis_tready,
    input  spf_stat_t stat,
    output spf_cmd_t  cmd
);

    spf_state_t state_reg;
    spf_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    if (s_axis_tuser == CMD_VERTEX)
                    begin
                        cmd.vtx_load = 1'b1;
                    end
                    else if (stat.nothing_left)
                    begin
                        state_next = ST_NONE;
                    end
                    else
                    begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_NONE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_none = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_INIT:
            begin
                cmd.row_init = 1'b1;
                state_next   = ST_FETCH;
            end
            ST_FETCH:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = stat.first ? ST_FETCH : ST_TEST;
            end
            ST_TEST:
            begin
                cmd.test   = 1'b1;
                state_next = stat.hit ? ST_MUL : ST_NEXT;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                cmd.store  = 1'b1;
                state_next = ST_NEXT;
            end
            ST_NEXT:
            begin
                cmd.next   = 1'b1;
                state_next = stat.last_edge ? ST_SORT : ST_FETCH;
            end
            ST_SORT:
            begin
                cmd.sort_step = 1'b1;
                if (stat.sort_done)
                begin
                    state_next = ST_PAIR;
                end
            end
            ST_PAIR:
            begin
                if (!stat.pair_more)
                begin
                    state_next = ST_FINISH;
                end
                else if (!(stat.span_ok && stat.pend_valid && !stat.out_free))
                begin
                    cmd.pair_step = 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_final = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `SPF_ASSERT_NXT(a_none_path, state_reg == ST_IDLE && s_axis_tvalid && s_axis_tuser == CMD_ROW && stat.nothing_left, state_reg == ST_NONE, "row command with nothing left not answered")
    `SPF_ASSERT_NXT(a_finish_exit, state_reg == ST_FINISH && stat.out_free, state_reg == ST_IDLE, "row not closed")
    `SPF_ASSERT_NXT(a_div_exit, state_reg == ST_DIV && stat.div_done, state_reg == ST_STORE, "quotient not stored")

endmodule

// ===== src/spf_dp.sv =====
`include "scanline_polygon_span_fill_unit_defines.svh"

module spf_dp
    import spf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  spf_cmd_t                  cmd,
    output spf_stat_t                 stat,
    input  logic signed [COORD_W-1:0] in_x,
    input  logic signed [COORD_W-1:0] in_y,
    input  logic                      in_last,
    input  logic [COLOR_W-1:0]        fill_color,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic [COL_W-1:0]          out_row,
    output logic [COL_W-1:0]          out_start,
    output logic [COL_W-1:0]          out_end,
    output logic [COLOR_W-1:0]        out_color,
    output logic                      out_span_valid,
    output logic                      out_row_last,
    output logic                      out_done
);

    localparam logic signed [12:0] ROW_MAX = 13'(SCREEN_HEIGHT - 1);
    localparam logic signed [12:0] COL_MAX = 13'(SCREEN_WIDTH - 1);
    localparam logic signed [COORD_W-1:0] PAD = {1'b0, {(COORD_W-1){1'b1}}};

    logic signed [COORD_W-1:0] vx_mem [MAX_VERTICES];
    logic signed [COORD_W-1:0] vy_mem [MAX_VERTICES];
    logic signed [COORD_W-1:0] rd_x_reg, rd_y_reg;

    logic [VCNT_W-1:0]         vcnt_reg;
    logic signed [COORD_W-1:0] min_y_reg, max_y_reg;
    logic [ROW_W-1:0]          cur_row_reg, end_row_reg;
    logic                      closed_reg;

    logic [VCNT_W-1:0]         ptr_reg;
    logic signed [COORD_W-1:0] v0_x_reg, v0_y_reg, prev_x_reg, prev_y_reg, cur_x_reg, cur_y_reg;
    logic [15:0]               t_reg, adx_reg, s_reg, rem_reg, lo_reg;
    logic                      neg_reg;
    logic [DIVC_W-1:0]         dcnt_reg;
    logic [XCNT_W-1:0]         scnt_reg;
    logic [XCNT_W-1:0]         xcnt_reg;
    logic [RES_W-1:0]          nres_reg;
    logic signed [COORD_W-1:0] list_reg [MAX_CROSSINGS];
    logic signed [COORD_W-1:0] sort_next [MAX_CROSSINGS];

    logic                      pend_valid_reg;
    logic [COL_W-1:0]          pend_start_reg, pend_end_reg;
    logic [COLOR_W-1:0]        pend_color_reg;

    logic                      out_valid_reg;
    logic [COL_W-1:0]          out_row_reg, out_start_reg, out_end_reg;
    logic [COLOR_W-1:0]        out_color_reg;
    logic                      out_sv_reg, out_last_reg, out_done_reg;

    // vertex load
    logic [VCNT_W-1:0]         eff_cnt, new_cnt;
    logic                      room;
    logic signed [COORD_W-1:0] new_min, new_max;
    logic signed [16:0]        min_p15;
    logic signed [12:0]        r0, r1, r0c, r1c;
    logic                      rows_empty;

    always_comb
    begin
        eff_cnt = closed_reg ? '0 : vcnt_reg;
        room    = eff_cnt < VCNT_W'(MAX_VERTICES);
        new_min = min_y_reg;
        new_max = max_y_reg;
        new_cnt = eff_cnt;
        if (room)
        begin
            new_cnt = eff_cnt + 1'b1;
            if (eff_cnt == '0)
            begin
                new_min = in_y;
                new_max = in_y;
            end
            else
            begin
                new_min = (in_y < min_y_reg) ? in_y : min_y_reg;
                new_max = (in_y > max_y_reg) ? in_y : max_y_reg;
            end
        end
        min_p15    = {new_min[COORD_W-1], new_min} + 17'sd15;
        r0         = min_p15[16:4];
        r1         = {new_max[COORD_W-1], new_max[COORD_W-1:4]};
        r0c        = (r0 < 0) ? 13'sd0 : r0;
        r1c        = (r1 > ROW_MAX) ? ROW_MAX : r1;
        rows_empty = r1c < r0c;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.vtx_load && room)
        begin
            vx_mem[eff_cnt[VADDR_W-1:0]] <= in_x;
            vy_mem[eff_cnt[VADDR_W-1:0]] <= in_y;
        end
        rd_x_reg <= vx_mem[ptr_reg[VADDR_W-1:0]];
        rd_y_reg <= vy_mem[ptr_reg[VADDR_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcnt_reg    <= '0;
            min_y_reg   <= '0;
            max_y_reg   <= '0;
            cur_row_reg <= '0;
            end_row_reg <= '0;
            closed_reg  <= 1'b0;
        end
        else if (cmd.vtx_load)
        begin
            vcnt_reg   <= new_cnt;
            min_y_reg  <= new_min;
            max_y_reg  <= new_max;
            closed_reg <= in_last && (new_cnt != '0);
            if (in_last && (new_cnt != '0))
            begin
                cur_row_reg <= rows_empty ? ROW_W'(1) : r0c[ROW_W-1:0];
                end_row_reg <= rows_empty ? '0 : r1c[ROW_W-1:0];
            end
        end
        else if (cmd.emit_final)
        begin
            cur_row_reg <= cur_row_reg + 1'b1;
        end
    end

    // edge walk
    logic signed [17:0] y_row, ya_e, yb_e, dy, dyy, dx, ady, adyy, adx_w;
    logic               hit;

    always_comb
    begin
        y_row = $signed({3'b000, cur_row_reg, 4'b0000});
        ya_e  = {{2{prev_y_reg[COORD_W-1]}}, prev_y_reg};
        yb_e  = {{2{cur_y_reg[COORD_W-1]}}, cur_y_reg};
        dy    = yb_e - ya_e;
        dyy   = y_row - ya_e;
        dx    = {{2{cur_x_reg[COORD_W-1]}}, cur_x_reg} - {{2{prev_x_reg[COORD_W-1]}}, prev_x_reg};
        ady   = dy[17] ? -dy : dy;
        adyy  = dyy[17] ? -dyy : dyy;
        adx_w = dx[17] ? -dx : dx;
        hit   = ((ya_e <= y_row && y_row < yb_e) || (yb_e <= y_row && y_row < ya_e))
                && (xcnt_reg < XCNT_W'(MAX_CROSSINGS));
    end

    // shift-subtract divider and crossing x
    logic [31:0]        prod;
    logic [16:0]        r2, r2_diff;
    logic               r2_ge;
    logic signed [17:0] qx, adj, xs;

    always_comb
    begin
        prod    = t_reg * adx_reg;
        r2      = {rem_reg, lo_reg[15]};
        r2_diff = r2 - {1'b0, s_reg};
        r2_ge   = r2 >= {1'b0, s_reg};
        qx      = $signed({2'b00, lo_reg}) + $signed({17'd0, rem_reg != '0 && neg_reg});
        adj     = neg_reg ? -qx : qx;
        xs      = {{2{prev_x_reg[COORD_W-1]}}, prev_x_reg} + adj;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (ptr_reg == '0)
            begin
                v0_x_reg   <= rd_x_reg;
                v0_y_reg   <= rd_y_reg;
                prev_x_reg <= rd_x_reg;
                prev_y_reg <= rd_y_reg;
            end
            else
            begin
                cur_x_reg <= (ptr_reg == vcnt_reg) ? v0_x_reg : rd_x_reg;
                cur_y_reg <= (ptr_reg == vcnt_reg) ? v0_y_reg : rd_y_reg;
            end
        end
        if (cmd.next)
        begin
            prev_x_reg <= cur_x_reg;
            prev_y_reg <= cur_y_reg;
        end
        if (cmd.test)
        begin
            t_reg   <= adyy[15:0];
            adx_reg <= adx_w[15:0];
            s_reg   <= ady[15:0];
            neg_reg <= dx[17];
        end
        if (cmd.mul)
        begin
            rem_reg <= prod[31:16];
            lo_reg  <= prod[15:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= r2_ge ? r2_diff[15:0] : r2[15:0];
            lo_reg  <= {lo_reg[14:0], r2_ge};
        end
    end

    // odd-even transposition sort
    always_comb
    begin
        sort_next = list_reg;
        for (int k = 0; k < MAX_CROSSINGS - 1; k++)
        begin
            if (((k % 2) == int'(scnt_reg[0])) && (list_reg[k] > list_reg[k + 1]))
            begin
                sort_next[k]     = list_reg[k + 1];
                sort_next[k + 1] = list_reg[k];
            end
        end
    end

    // pairing
    logic signed [16:0] c0p;
    logic signed [12:0] xa, xb, xa_c, xb_c;
    logic               span_ok;

    always_comb
    begin
        c0p     = {list_reg[0][COORD_W-1], list_reg[0]} + 17'sd15;
        xa      = c0p[16:4];
        xb      = {list_reg[1][COORD_W-1], list_reg[1][COORD_W-1:4]};
        xa_c    = (xa < 0) ? 13'sd0 : xa;
        xb_c    = (xb > COL_MAX) ? COL_MAX : xb;
        span_ok = xb_c >= xa_c;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.row_init)
        begin
            for (int k = 0; k < MAX_CROSSINGS; k++)
            begin
                list_reg[k] <= PAD;
            end
        end
        else if (cmd.store)
        begin
            list_reg[xcnt_reg[XIDX_W-1:0]] <= xs[COORD_W-1:0];
        end
        else if (cmd.sort_step)
        begin
            list_reg <= sort_next;
        end
        else if (cmd.pair_step)
        begin
            for (int k = 0; k < MAX_CROSSINGS; k++)
            begin
                list_reg[k] <= (k + 2 < MAX_CROSSINGS) ? list_reg[(k + 2) % MAX_CROSSINGS] : PAD;
            end
        end
        if (cmd.pair_step && span_ok)
        begin
            pend_start_reg <= xa_c[COL_W-1:0];
            pend_end_reg   <= xb_c[COL_W-1:0];
            pend_color_reg <= fill_color;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg        <= '0;
            dcnt_reg       <= '0;
            scnt_reg       <= '0;
            xcnt_reg       <= '0;
            nres_reg       <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.row_init)
            begin
                ptr_reg        <= '0;
                dcnt_reg       <= '0;
                scnt_reg       <= '0;
                xcnt_reg       <= '0;
                nres_reg       <= '0;
                pend_valid_reg <= 1'b0;
            end
            if (cmd.load && ptr_reg == '0)
            begin
                ptr_reg <= VCNT_W'(1);
            end
            if (cmd.next)
            begin
                ptr_reg <= ptr_reg + 1'b1;
            end
            if (cmd.div_step)
            begin
                dcnt_reg <= dcnt_reg + 1'b1;
            end
            if (cmd.store)
            begin
                xcnt_reg <= xcnt_reg + 1'b1;
            end
            if (cmd.sort_step)
            begin
                scnt_reg <= scnt_reg + 1'b1;
            end
            if (cmd.pair_step)
            begin
                xcnt_reg <= xcnt_reg - XCNT_W'(2);
                if (span_ok)
                begin
                    pend_valid_reg <= 1'b1;
                    nres_reg       <= nres_reg + 1'b1;
                end
            end
        end
    end

    // result register
    logic row_done, emit_pend, emit_any;

    assign row_done  = cur_row_reg == end_row_reg;
    assign emit_pend = cmd.pair_step && span_ok && pend_valid_reg;
    assign emit_any  = emit_pend || cmd.emit_final || cmd.emit_none;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_any)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_none)
        begin
            out_row_reg   <= '0;
            out_start_reg <= '0;
            out_end_reg   <= '0;
            out_color_reg <= '0;
            out_sv_reg    <= 1'b0;
            out_last_reg  <= 1'b1;
            out_done_reg  <= 1'b1;
        end
        else if (emit_pend || cmd.emit_final)
        begin
            out_row_reg   <= cur_row_reg[COL_W-1:0];
            out_start_reg <= pend_valid_reg ? pend_start_reg : '0;
            out_end_reg   <= pend_valid_reg ? pend_end_reg : '0;
            out_color_reg <= pend_valid_reg ? pend_color_reg : '0;
            out_sv_reg    <= pend_valid_reg;
            out_last_reg  <= cmd.emit_final;
            out_done_reg  <= row_done;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_row        = out_row_reg;
    assign out_start      = out_start_reg;
    assign out_end        = out_end_reg;
    assign out_color      = out_color_reg;
    assign out_span_valid = out_sv_reg;
    assign out_row_last   = out_last_reg;
    assign out_done       = out_done_reg;

    always_comb
    begin
        stat              = '0;
        stat.nothing_left = !closed_reg || (cur_row_reg > end_row_reg);
        stat.first        = ptr_reg == '0;
        stat.last_edge    = ptr_reg == vcnt_reg;
        stat.hit          = hit;
        stat.div_done     = dcnt_reg == DIVC_W'(DIV_STEPS - 1);
        stat.sort_done    = scnt_reg == XCNT_W'(MAX_CROSSINGS - 1);
        stat.pair_more    = (xcnt_reg >= XCNT_W'(2)) && (nres_reg < RES_W'(MAX_RESULTS));
        stat.span_ok      = span_ok;
        stat.pend_valid   = pend_valid_reg;
        stat.out_free     = !out_valid_reg || out_ready;
    end

    `SPF_ASSERT_IMP(a_emit_free, emit_any, !out_valid_reg || out_ready, "result register overwritten")
    `SPF_ASSERT_IMP(a_xcnt_max, 1'b1, xcnt_reg <= XCNT_W'(MAX_CROSSINGS), "crossing count overflow")
    `SPF_ASSERT_IMP(a_pair_two, cmd.pair_step, xcnt_reg >= XCNT_W'(2), "pairing without two crossings")

endmodule

// ===== src/scanline_polygon_span_fill_unit.sv =====
// Even-odd scanline span fill. A vertex beat (tuser 0) stores one Q11.4 vertex while the
// vertex memory has room; tlast closes the polygon. A row beat (tuser 1) rasterises the next
// row and returns one to eight span beats, the last with tlast. To work a row beat, every
// edge is read back from the vertex memory one at a time, each crossing runs through one
// shared 16-step shift-subtract divider, and the crossings are sorted in 16 transposition
// passes. No new beat is taken while a row is being worked on.
`include "scanline_polygon_span_fill_unit_defines.svh"

module scanline_polygon_span_fill_unit
    import spf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [SDATA_W-1:0] s_axis_tdata,  // vertex_x, vertex_y
    input  logic               s_axis_tuser,  // command
    input  logic               s_axis_tlast,  // vertex_last
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [MDATA_W-1:0] m_axis_tdata,  // row, span_start, span_end, span_color,
                                              // polygon_done, zero pad
    output logic               m_axis_tuser,  // span_valid
    output logic               m_axis_tlast   // row_last
);

    logic [COLOR_W-1:0] fill_color_reg;
    spf_cmd_t           cmd;
    spf_stat_t          stat;
    logic [COL_W-1:0]   o_row, o_start, o_end;
    logic [COLOR_W-1:0] o_color;
    logic               o_done;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_color_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_FILL_COLOR)
        begin
            fill_color_reg <= pwdata[COLOR_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_FILL_COLOR) ? {16'd0, fill_color_reg} : 32'd0;

    spf_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    spf_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .in_x           (s_axis_tdata[15:0]),
        .in_y           (s_axis_tdata[31:16]),
        .in_last        (s_axis_tlast),
        .fill_color     (fill_color_reg),
        .out_ready      (m_axis_tready),
        .out_valid      (m_axis_tvalid),
        .out_row        (o_row),
        .out_start      (o_start),
        .out_end        (o_end),
        .out_color      (o_color),
        .out_span_valid (m_axis_tuser),
        .out_row_last   (m_axis_tlast),
        .out_done       (o_done)
    );

    assign m_axis_tdata = {1'b0, o_done, o_color, o_end, o_start, o_row};

endmodule

// ===== verif/scanline_polygon_span_fill_unit_tb.sv =====
module scanline_polygon_span_fill_unit_tb;
    import spf_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 400;
    localparam int ITEM_TARGET    = 360;

    typedef struct packed {
        logic [9:0]  row;
        logic [9:0]  span_start;
        logic [9:0]  span_end;
        logic [15:0] span_color;
        logic        span_valid;
        logic        row_last;
        logic        polygon_done;
    } span_t;

    typedef struct {
        logic               cmd;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               last;
        bit                 known;
        span_t              want;
    } beat_row_t;

    localparam span_t NOTHING_LEFT = '{row: 10'd0, span_start: 10'd0, span_end: 10'd0,
                                       span_color: 16'd0, span_valid: 1'b0,
                                       row_last: 1'b1, polygon_done: 1'b1};

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [SDATA_W-1:0] s_axis_tdata;
    logic               s_axis_tuser;
    logic               s_axis_tlast;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [MDATA_W-1:0] m_axis_tdata;
    logic               m_axis_tuser;
    logic               m_axis_tlast;

    scanline_polygon_span_fill_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // shadow of the block
    logic [15:0] shadow_color;
    int          shadow_vx [MAX_VERTICES];
    int          shadow_vy [MAX_VERTICES];
    int          shadow_count;
    int          shadow_min_y;
    int          shadow_max_y;
    int          shadow_row;
    int          shadow_end_row;
    bit          shadow_closed;

    span_t span_q [$];
    int    err_cnt;
    int    items_sent;
    int    idle_cycles;
    bit    quiet;
    bit    hold_req;
    int    hold_cnt;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic longint floor_div(input longint n, input longint d);
        longint q;
        q = n / d;
        if ((n % d != 0) && ((n < 0) != (d < 0)))
            q--;
        return q;
    endfunction

    task automatic predict_spans(input logic cmd, input logic signed [15:0] vx,
                                 input logic signed [15:0] vy, input logic vlast,
                                 input bit known, input span_t want);
        int     r0;
        int     r1;
        int     ybig;
        int     cnt;
        int     nres;
        int     j;
        int     b;
        int     v;
        int     ya;
        int     yb;
        longint num;
        longint xa;
        longint xb;
        int     xs [MAX_CROSSINGS];
        span_t  res [$];
        span_t  s;
        bit     dn;
        if (cmd == CMD_VERTEX)
        begin
            if (shadow_closed)
            begin
                shadow_count  = 0;
                shadow_closed = 1'b0;
            end
            if (shadow_count < MAX_VERTICES)
            begin
                shadow_vx[shadow_count] = int'(vx);
                shadow_vy[shadow_count] = int'(vy);
                if (shadow_count == 0)
                begin
                    shadow_min_y = int'(vy);
                    shadow_max_y = int'(vy);
                end
                else
                begin
                    if (int'(vy) < shadow_min_y) shadow_min_y = int'(vy);
                    if (int'(vy) > shadow_max_y) shadow_max_y = int'(vy);
                end
                shadow_count++;
            end
            if (vlast && shadow_count > 0)
            begin
                r0 = int'(-floor_div(-longint'(shadow_min_y), 16));
                r1 = int'(floor_div(longint'(shadow_max_y), 16));
                if (r0 < 0) r0 = 0;
                if (r1 > SCREEN_HEIGHT - 1) r1 = SCREEN_HEIGHT - 1;
                shadow_closed = 1'b1;
                if (r1 < r0)
                begin
                    shadow_row     = 1;
                    shadow_end_row = 0;
                end
                else
                begin
                    shadow_row     = r0;
                    shadow_end_row = r1;
                end
            end
            return;
        end
        if (!shadow_closed || shadow_row > shadow_end_row)
            res.push_back(NOTHING_LEFT);
        else
        begin
            ybig = shadow_row * 16;
            dn   = (shadow_row == shadow_end_row);
            cnt  = 0;
            for (int i = 0; i < shadow_count; i++)
            begin
                j  = (i + 1) % shadow_count;
                ya = shadow_vy[i];
                yb = shadow_vy[j];
                if ((ya <= ybig && ybig < yb) || (yb <= ybig && ybig < ya))
                begin
                    num = longint'(ybig - ya) * longint'(shadow_vx[j] - shadow_vx[i]);
                    if (cnt < MAX_CROSSINGS)
                    begin
                        xs[cnt] = int'(longint'(shadow_vx[i]) + floor_div(num, yb - ya));
                        cnt++;
                    end
                end
            end
            for (int a = 1; a < cnt; a++)
            begin
                v = xs[a];
                b = a - 1;
                while (b >= 0 && xs[b] > v)
                begin
                    xs[b + 1] = xs[b];
                    b--;
                end
                xs[b + 1] = v;
            end
            nres = 0;
            for (int a = 0; a + 1 < cnt && nres < MAX_RESULTS; a += 2)
            begin
                xa = -floor_div(-longint'(xs[a]), 16);
                xb = floor_div(longint'(xs[a + 1]), 16);
                if (xa < 0) xa = 0;
                if (xb > SCREEN_WIDTH - 1) xb = SCREEN_WIDTH - 1;
                if (xb >= xa)
                begin
                    s = '{row: 10'(shadow_row), span_start: 10'(xa), span_end: 10'(xb),
                          span_color: shadow_color, span_valid: 1'b1, row_last: 1'b0,
                          polygon_done: dn};
                    res.push_back(s);
                    nres++;
                end
            end
            if (nres == 0)
            begin
                s = '{row: 10'(shadow_row), span_start: 10'd0, span_end: 10'd0,
                      span_color: 16'd0, span_valid: 1'b0, row_last: 1'b1,
                      polygon_done: dn};
                res.push_back(s);
            end
            else
                res[nres - 1].row_last = 1'b1;
            shadow_row++;
        end
        if (known)
            span_q.push_back(want);
        else
            foreach (res[k])
                span_q.push_back(res[k]);
    endtask

    task automatic send_beat(input logic cmd, input logic signed [15:0] vx,
                             input logic signed [15:0] vy, input logic vlast,
                             input bit known = 1'b0, input span_t want = '0);
        int g;
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 70)
            g = 0;
        else if (r < 97)
            g = $urandom_range(1, 4);
        else
            g = $urandom_range(20, 80);
        repeat (g)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {vy, vx};
        s_axis_tuser  <= cmd;
        s_axis_tlast  <= vlast;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_spans(cmd, vx, vy, vlast, known, want);
        items_sent++;
    endtask

    task automatic drain;
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (span_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_color(input logic [15:0] c);
        drain();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * REG_FILL_COLOR);
        pwdata  <= {16'($urandom), c};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow_color = c;
    endtask

    task automatic random_row;
        send_beat(CMD_ROW, 16'($urandom), 16'($urandom), 1'($urandom));
    endtask

    task automatic random_polygon;
        int kind;
        int n;
        int bx;
        int by;
        int h;
        int w;
        int ylo;
        int yhi;
        logic signed [15:0] px;
        logic signed [15:0] py;
        kind = $urandom_range(0, 99);
        bx   = $urandom_range(0, 2400) - 300;
        by   = $urandom_range(0, 2800) - 200;
        h    = $urandom_range(0, 200);
        if (kind < 60)
        begin
            n = $urandom_range(3, 8);
            for (int k = 0; k < n; k++)
            begin
                px = 16'(bx + $urandom_range(0, 1200) - 600);
                py = 16'(by + $urandom_range(0, h));
                send_beat(CMD_VERTEX, px, py, k == n - 1);
                if ($urandom_range(0, 99) < 4)
                    random_row();
            end
        end
        else if (kind < 75)
        begin
            // comb: many crossings and spans per row
            n   = $urandom_range(9, 14);
            w   = $urandom_range(24, 200);
            ylo = by;
            yhi = by + $urandom_range(16, 120);
            bx  = $urandom_range(0, 400) - 100;
            for (int k = 0; k < n; k++)
            begin
                send_beat(CMD_VERTEX, 16'(bx + k * w), 16'(ylo), 1'b0);
                send_beat(CMD_VERTEX, 16'(bx + k * w + w / 2), 16'(yhi), 1'b0);
            end
            send_beat(CMD_VERTEX, 16'(bx + n * w), 16'(yhi + 32), 1'b0);
            send_beat(CMD_VERTEX, 16'(bx), 16'(yhi + 32), 1'b1);
        end
        else if (kind < 88)
        begin
            n = $urandom_range(1, 6);
            for (int k = 0; k < n; k++)
                send_beat(CMD_VERTEX, 16'($urandom), 16'($urandom), k == n - 1);
        end
        else
        begin
            n = $urandom_range(1, 2);
            for (int k = 0; k < n; k++)
                send_beat(CMD_VERTEX, 16'(bx + $urandom_range(0, 300)),
                          16'(by + $urandom_range(0, 64)), k == n - 1);
        end
        n = $urandom_range(0, 14);
        for (int k = 0; k < n; k++)
            random_row();
    endtask

    task automatic overflow_polygon;
        for (int k = 0; k < MAX_VERTICES + 2; k++)
            send_beat(CMD_VERTEX, 16'($urandom_range(0, 2100) - 50),
                      16'($urandom_range(0, 400)), k == MAX_VERTICES + 1);
        repeat (3) random_row();
    endtask

    beat_row_t directed [] = '{
        '{CMD_ROW, 16'sd0, 16'sd0, 1'b0, 1'b1, NOTHING_LEFT},
        '{CMD_VERTEX, 16'sd0, 16'sd0, 1'b0, 1'b0, '0},
        '{CMD_VERTEX, 16'sd320, 16'sd0, 1'b0, 1'b0, '0},
        '{CMD_VERTEX, 16'sd0, 16'sd320, 1'b1, 1'b0, '0},
        '{CMD_ROW, 16'sd0, 16'sd0, 1'b0, 1'b0, '0},
        '{CMD_ROW, 16'sd0, 16'sd0, 1'b0, 1'b0, '0},
        '{CMD_ROW, -16'sd1, -16'sd1, 1'b1, 1'b0, '0},
        '{CMD_VERTEX, -16'sd32768, -16'sd32768, 1'b0, 1'b0, '0},
        '{CMD_VERTEX, 16'sd32767, 16'sd32767, 1'b0, 1'b0, '0},
        '{CMD_VERTEX, -16'sd32768, 16'sd32767, 1'b1, 1'b0, '0},
        '{CMD_ROW, 16'sd32767, -16'sd32768, 1'b0, 1'b0, '0},
        '{CMD_ROW, 16'sd0, 16'sd0, 1'b0, 1'b0, '0},
        '{CMD_VERTEX, 16'sd0, -16'sd320, 1'b0, 1'b0, '0},
        '{CMD_VERTEX, 16'sd100, -16'sd160, 1'b1, 1'b0, '0},
        '{CMD_ROW, 16'sd0, 16'sd0, 1'b0, 1'b1, NOTHING_LEFT},
        '{CMD_VERTEX, 16'sd16, 16'sd16, 1'b1, 1'b0, '0},
        '{CMD_ROW, 16'sd0, 16'sd0, 1'b0, 1'b1,
          '{10'd1, 10'd0, 10'd0, 16'd0, 1'b0, 1'b1, 1'b1}},
        '{CMD_ROW, 16'sd0, 16'sd0, 1'b0, 1'b1, NOTHING_LEFT},
        '{CMD_VERTEX, 16'sd0, 16'sd0, 1'b0, 1'b0, '0},
        '{CMD_VERTEX, 16'sd160, 16'sd160, 1'b1, 1'b0, '0},
        '{CMD_ROW, 16'sd0, 16'sd0, 1'b0, 1'b0, '0},
        '{CMD_VERTEX, 16'sd16, 16'sd16, 1'b0, 1'b0, '0},
        '{CMD_VERTEX, 16'sd1600, 16'sd16, 1'b0, 1'b0, '0},
        '{CMD_VERTEX, 16'sd1600, 16'sd48, 1'b0, 1'b0, '0},
        '{CMD_VERTEX, 16'sd16, 16'sd48, 1'b1, 1'b0, '0},
        '{CMD_ROW, 16'sd0, 16'sd0, 1'b0, 1'b0, '0}
    };

    always @(negedge clk)
    begin
        if (hold_cnt > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_cnt      <= hold_cnt - 1;
        end
        else if (hold_req)
        begin
            m_axis_tready <= 1'b0;
            hold_cnt      <= HOLD_CYCLES;
            hold_req      <= 1'b0;
        end
        else if (quiet)
            m_axis_tready <= 1'b1;
        else
        begin
            automatic int r = $urandom_range(0, 99);
            if (r < 60)
                m_axis_tready <= 1'b1;
            else if (r < 96)
                m_axis_tready <= 1'b0;
            else
            begin
                m_axis_tready <= 1'b0;
                hold_cnt      <= $urandom_range(10, 60);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            automatic span_t got = '{row: m_axis_tdata[9:0], span_start: m_axis_tdata[19:10],
                                     span_end: m_axis_tdata[29:20],
                                     span_color: m_axis_tdata[45:30],
                                     span_valid: m_axis_tuser, row_last: m_axis_tlast,
                                     polygon_done: m_axis_tdata[46]};
            automatic span_t want;
            if (span_q.size() == 0)
            begin
                $error("span beat with nothing expected: %p", got);
                err_cnt++;
            end
            else
            begin
                want = span_q.pop_front();
                if (got.row != want.row)
                begin
                    $error("row exp %0d got %0d", want.row, got.row);
                    err_cnt++;
                end
                if (got.span_start != want.span_start)
                begin
                    $error("span_start exp %0d got %0d", want.span_start, got.span_start);
                    err_cnt++;
                end
                if (got.span_end != want.span_end)
                begin
                    $error("span_end exp %0d got %0d", want.span_end, got.span_end);
                    err_cnt++;
                end
                if (got.span_color != want.span_color)
                begin
                    $error("span_color exp %h got %h", want.span_color, got.span_color);
                    err_cnt++;
                end
                if (got.span_valid != want.span_valid)
                begin
                    $error("span_valid exp %0d got %0d", want.span_valid, got.span_valid);
                    err_cnt++;
                end
                if (got.row_last != want.row_last)
                begin
                    $error("row_last exp %0d got %0d", want.row_last, got.row_last);
                    err_cnt++;
                end
                if (got.polygon_done != want.polygon_done)
                begin
                    $error("polygon_done exp %0d got %0d", want.polygon_done,
                           got.polygon_done);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("scanline_polygon_span_fill_unit_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_VERTEX;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        err_cnt       = 0;
        items_sent    = 0;
        idle_cycles   = 0;
        quiet         = 1'b0;
        hold_req      = 1'b0;
        hold_cnt      = 0;
        shadow_color  = '0;
        shadow_count  = 0;
        shadow_min_y  = 0;
        shadow_max_y  = 0;
        shadow_row    = 0;
        shadow_end_row = 0;
        shadow_closed = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[k])
            send_beat(directed[k].cmd, directed[k].x, directed[k].y, directed[k].last,
                      directed[k].known, directed[k].want);
        write_color(16'hFFFF);
        foreach (directed[k])
            if (!directed[k].known)
                send_beat(directed[k].cmd, directed[k].x, directed[k].y, directed[k].last);

        overflow_polygon();
        while (items_sent < ITEM_TARGET)
        begin
            case ((items_sent / 60) % 4)
                0: write_color(16'($urandom));
                1: write_color(16'h0000);
                2: write_color(16'hFFFF);
                default: write_color(16'($urandom));
            endcase
            quiet = ($urandom_range(0, 3) == 0);
            if (items_sent > 150 && items_sent < 220)
                hold_req = 1'b1;
            repeat (4) random_polygon();
        end

        drain();
        repeat (1000) @(posedge clk);
        if (err_cnt == 0)
            $display("scanline_polygon_span_fill_unit_tb: done, clean");
        else
            $display("scanline_polygon_span_fill_unit_tb: done, errors");
        $finish;
    end

endmodule
